@@ design/assert_macros.svh @@
// Assertion macros shared by the convolver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

@@ design/xfir_pkg.sv @@
// Shared types, widths and constants of the crossfading convolver.
package xfir_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_TAPS_DEF  = 16384;
    localparam int TAP_IDX_W     = 14;
    localparam int IR_LEN_W      = 15;
    localparam int XLEN_W        = 20;
    localparam int XRECIP_W      = 25;
    localparam int GAIN_W        = 25;
    localparam int PROD_W        = XLEN_W + XRECIP_W;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 25;

    localparam logic [GAIN_W-1:0]   GAIN_ONE        = 25'h1000000;
    localparam logic [XLEN_W-1:0]   XLEN_RESET      = 20'd4800;
    localparam logic [XRECIP_W-1:0] XRECIP_RESET    = 25'd3495;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_XFADE_LEN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XFADE_RECIP = 4'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        CMD_AUDIO   = 2'd0,
        CMD_TAP     = 2'd1,
        CMD_PUBLISH = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Tap bank identifiers; three banks rotate through live, next and pending.
    typedef logic [1:0] bank_id_t;
    localparam bank_id_t BANK_A = 2'd0;
    localparam bank_id_t BANK_B = 2'd1;
    localparam bank_id_t BANK_C = 2'd2;

    // Control of one multiply-accumulate lane.
    typedef struct packed {
        logic clr;
        logic en;
    } lane_ctl_t;

    // Control of the merging stage.
    typedef struct packed {
        logic              start;
        logic              fade;
        logic [PROD_W-1:0] prod;
    } mix_ctl_t;

endpackage

@@ design/xfir_stream_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface xfir_item_if;
    logic               valid;
    logic               ready;
    xfir_pkg::cmd_t     cmd;
    xfir_pkg::sample_t  left_in;
    xfir_pkg::sample_t  right_in;
    logic [xfir_pkg::TAP_IDX_W-1:0] tap_index;
    xfir_pkg::sample_t  tap_value;
    logic [xfir_pkg::IR_LEN_W-1:0]  ir_length;

    modport source (output valid, cmd, left_in, right_in, tap_index, tap_value, ir_length,
                    input ready);
    modport sink   (input valid, cmd, left_in, right_in, tap_index, tap_value, ir_length,
                    output ready);
endinterface

interface xfir_result_if;
    logic               valid;
    logic               ready;
    xfir_pkg::sample_t  left_out;
    xfir_pkg::sample_t  right_out;
    logic               fading;
    logic               ir_live;

    modport source (output valid, left_out, right_out, fading, ir_live, input ready);
    modport sink   (input valid, left_out, right_out, fading, ir_live, output ready);
endinterface

@@ design/xfir_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module xfir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/xfir_lane.sv @@
// One multiply-accumulate lane: tap times sample, summed over the tap walk.
module xfir_lane #(
    parameter int ACC_W = 62
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  xfir_pkg::lane_ctl_t     ctl,
    input  xfir_pkg::sample_t       tap,
    input  xfir_pkg::sample_t       smp,
    output logic signed [ACC_W-1:0] acc
);

    localparam int PW = 2 * xfir_pkg::SAMPLE_BITS;

    logic signed [PW-1:0]    prod_reg;
    logic                    prod_valid_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Product stage; its valid flag is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctl.en;
        end
    end

    // Multiplier register and accumulator.
    always_ff @(posedge clk)
    begin
        prod_reg <= tap * smp;
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

@@ design/xfir_mix.sv @@
// Merging stage: rounds the lane sums, applies the crossfade gains and saturates.
module xfir_mix #(
    parameter int ACC_W = 62
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  xfir_pkg::mix_ctl_t      ctl,
    input  logic signed [ACC_W-1:0] acc_cur [2],
    input  logic signed [ACC_W-1:0] acc_nxt [2],
    output logic                    done,
    output xfir_pkg::sample_t       y_out [2]
);

    localparam int SB    = xfir_pkg::SAMPLE_BITS;
    localparam int GW    = xfir_pkg::GAIN_W;
    localparam int YW    = ACC_W - (SB - 1);
    localparam int LO_W  = 17;
    localparam int HI_W  = YW - LO_W;
    localparam int PLO_W = LO_W + GW;
    localparam int PHI_W = HI_W + GW + 1;
    localparam int MIX_W = YW + GW + 2;
    localparam int QW    = MIX_W - 24;

    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (SB - 2);
    localparam logic [MIX_W-1:0] MIX_HALF = MIX_W'(1) << 23;
    localparam logic signed [QW-1:0] Q_MAX = QW'((2 ** (SB - 1)) - 1);
    localparam logic signed [QW-1:0] Q_MIN = QW'(-(2 ** (SB - 1)));

    logic [3:0]              vld_reg;
    logic signed [YW-1:0]    yc_reg [2];
    logic signed [YW-1:0]    yn_reg [2];
    logic [GW-1:0]           g_reg;
    logic [GW-1:0]           gc_reg;
    logic [PLO_W-1:0]        plo_c_reg [2];
    logic [PLO_W-1:0]        plo_n_reg [2];
    logic signed [PHI_W-1:0] phi_c_reg [2];
    logic signed [PHI_W-1:0] phi_n_reg [2];
    logic signed [MIX_W-1:0] mix_reg [2];
    xfir_pkg::sample_t       y_reg [2];
    logic [GW-1:0]           g_calc;

    // Gain of the incoming response, clamped at zero.
    always_comb
    begin
        g_calc = '0;
        if (ctl.fade && (ctl.prod < xfir_pkg::PROD_W'(xfir_pkg::GAIN_ONE)))
        begin
            g_calc = xfir_pkg::GAIN_ONE - GW'(ctl.prod);
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], ctl.start};
        end
    end

    // Four-stage datapath: round, partial products, sum, saturate.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            g_reg  <= g_calc;
            gc_reg <= xfir_pkg::GAIN_ONE - g_calc;
        end
        for (int ch = 0; ch < 2; ch++)
        begin
            logic [ACC_W-1:0] sc;
            logic [ACC_W-1:0] sn;
            logic signed [QW-1:0] q;
            sc = acc_cur[ch] + ACC_HALF;
            sn = acc_nxt[ch] + ACC_HALF;
            if (ctl.start)
            begin
                yc_reg[ch] <= sc[ACC_W-1:SB-1];
                yn_reg[ch] <= sn[ACC_W-1:SB-1];
            end
            plo_c_reg[ch] <= PLO_W'(yc_reg[ch][LO_W-1:0]) * PLO_W'(gc_reg);
            plo_n_reg[ch] <= PLO_W'(yn_reg[ch][LO_W-1:0]) * PLO_W'(g_reg);
            phi_c_reg[ch] <= PHI_W'(signed'(yc_reg[ch][YW-1:LO_W]))
                           * PHI_W'(signed'({1'b0, gc_reg}));
            phi_n_reg[ch] <= PHI_W'(signed'(yn_reg[ch][YW-1:LO_W]))
                           * PHI_W'(signed'({1'b0, g_reg}));
            mix_reg[ch] <= (MIX_W'(phi_c_reg[ch]) <<< LO_W) + MIX_W'(plo_c_reg[ch])
                         + (MIX_W'(phi_n_reg[ch]) <<< LO_W) + MIX_W'(plo_n_reg[ch])
                         + MIX_HALF;
            q = mix_reg[ch][MIX_W-1:24];
            if (q > Q_MAX)
            begin
                y_reg[ch] <= SB'(Q_MAX);
            end
            else if (q < Q_MIN)
            begin
                y_reg[ch] <= SB'(Q_MIN);
            end
            else
            begin
                y_reg[ch] <= SB'(q);
            end
        end
    end

    assign done  = vld_reg[3];
    assign y_out = y_reg;

endmodule

@@ design/crossfading_ir_convolver.sv @@
// Top level of the stereo convolver with crossfaded impulse-response exchange.
//
// Channel  | Kind             | Carries
// item     | valid/ready sink | cmd, left_in, right_in, tap_index, tap_value, ir_length
// result   | valid/ready src  | left_out, right_out, fading, ir_live
// cfg      | write only       | cfg_we, cfg_index, cfg_data
//
// Tap writes, publishes and history resets are handled in the idle state. A
// convolved audio frame walks N taps, N being the longer of the live and (during a fade)
// next response lengths: one tap per cycle through four parallel MAC lanes
// fed by the tap bank and history RAM ports. Passthrough frames go straight to delivery.
// History is emptied by a fill count, so reset and history reset need no sweep.
// A waiting result does not stall input; a new frame waits only for delivery.
`include "assert_macros.svh"

module crossfading_ir_convolver #(
    parameter int MAX_TAPS = xfir_pkg::MAX_TAPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    xfir_item_if.sink                         item,
    xfir_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [xfir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xfir_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SB    = xfir_pkg::SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_TAPS);
    localparam int LW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 2 * SB + AW;
    localparam int XW    = xfir_pkg::XLEN_W;
    localparam int PW    = xfir_pkg::PROD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MIXGO,
        ST_MIX,
        ST_DELIVER
    } state_t;

    typedef xfir_pkg::bank_id_t bank_t;

    // Control state.
    state_t state_reg, state_next;
    logic [XW-1:0] xlen_reg, xlen_next;
    logic [xfir_pkg::XRECIP_W-1:0] xrecip_reg, xrecip_next;
    bank_t live_reg, live_next, next_reg, next_next, pend_reg, pend_next;
    logic [LW-1:0] len_reg [3];
    logic [LW-1:0] len_next [3];
    logic pending_reg, pending_next, loaded_reg, loaded_next;
    logic [XW-1:0] rem_reg, rem_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] k_reg, k_next;
    logic drain_reg, drain_next;
    logic en_cur_reg, en_nxt_reg;
    logic out_valid_reg, out_valid_next;

    // Frame snapshot and payload registers.
    bank_t cur_bank_reg, cur_bank_next, nxt_bank_reg, nxt_bank_next;
    logic [LW-1:0] len_cur_reg, len_cur_next, len_nxt_reg, len_nxt_next;
    logic [LW-1:0] klen_reg, klen_next, fill_snap_reg, fill_snap_next;
    logic [AW-1:0] ptr_snap_reg, ptr_snap_next;
    logic fade_reg, fade_next;
    logic [XW-1:0] rem_snap_reg, rem_snap_next;
    logic [PW-1:0] prod_reg;
    xfir_pkg::sample_t res_left_reg, res_left_next, res_right_reg, res_right_next;
    logic res_fading_reg, res_fading_next, res_live_reg, res_live_next;
    xfir_pkg::sample_t out_left_reg, out_left_next, out_right_reg, out_right_next;
    logic out_fading_reg, out_fading_next, out_live_reg, out_live_next;

    // Datapath wiring.
    logic accept;
    logic hist_we;
    logic [AW-1:0] hist_raddr;
    logic [SB-1:0] hist_l_q, hist_r_q;
    logic [SB-1:0] bank_q [3];
    logic [2:0] bank_we;
    logic tap_ok;
    xfir_pkg::sample_t tap_cur, tap_nxt;
    xfir_pkg::lane_ctl_t ctl_cur, ctl_nxt;
    logic signed [ACC_W-1:0] acc_cur [2];
    logic signed [ACC_W-1:0] acc_nxt [2];
    xfir_pkg::mix_ctl_t mix_ctl;
    logic mix_done;
    xfir_pkg::sample_t mix_y [2];

    // Adoption and fade bookkeeping for an audio frame.
    logic adopt, first_ir, fade_now, fade_end;
    bank_t a_next, a_pend, a_live, a_nx2;
    logic [XW-1:0] a_rem, rem_dec;
    logic [LW-1:0] a_len_live, a_len_nxt, ir_len_clamped;
    logic [AW:0] hist_diff;
    logic [LW-1:0] k_last;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        adopt      = pending_reg && (rem_reg == '0);
        a_next     = adopt ? pend_reg : next_reg;
        a_pend     = adopt ? next_reg : pend_reg;
        first_ir   = adopt && !loaded_reg;
        a_live     = first_ir ? a_next : live_reg;
        a_nx2      = first_ir ? live_reg : a_next;
        a_rem      = rem_reg;
        if (adopt && loaded_reg)
        begin
            a_rem = (xlen_reg == '0) ? XW'(1) : xlen_reg;
        end
        fade_now   = (a_rem != '0);
        rem_dec    = a_rem - XW'(1);
        fade_end   = fade_now && (rem_dec == '0);
        a_len_live = len_reg[a_live];
        a_len_nxt  = fade_now ? len_reg[a_nx2] : '0;
    end

    // Publish length, clamped to the bank depth.
    assign ir_len_clamped = (int'(item.ir_length) > MAX_TAPS) ? LW'(MAX_TAPS)
                                                              : LW'(item.ir_length);
    assign tap_ok = (int'(item.tap_index) < MAX_TAPS);

    // History read address walks backwards from the newest sample.
    assign hist_diff  = {1'b0, ptr_snap_reg} - (AW + 1)'(k_reg);
    assign hist_raddr = hist_diff[AW] ? AW'(hist_diff + (AW + 1)'(MAX_TAPS))
                                      : hist_diff[AW-1:0];
    assign k_last     = klen_reg - LW'(1);

    // Next-state logic of the sequencer and the control registers.
    always_comb
    begin
        state_next      = state_reg;
        xlen_next       = xlen_reg;
        xrecip_next     = xrecip_reg;
        live_next       = live_reg;
        next_next       = next_reg;
        pend_next       = pend_reg;
        len_next        = len_reg;
        pending_next    = pending_reg;
        loaded_next     = loaded_reg;
        rem_next        = rem_reg;
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        drain_next      = drain_reg;
        out_valid_next  = out_valid_reg;
        cur_bank_next   = cur_bank_reg;
        nxt_bank_next   = nxt_bank_reg;
        len_cur_next    = len_cur_reg;
        len_nxt_next    = len_nxt_reg;
        klen_next       = klen_reg;
        fill_snap_next  = fill_snap_reg;
        ptr_snap_next   = ptr_snap_reg;
        fade_next       = fade_reg;
        rem_snap_next   = rem_snap_reg;
        res_left_next   = res_left_reg;
        res_right_next  = res_right_reg;
        res_fading_next = res_fading_reg;
        res_live_next   = res_live_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_fading_next = out_fading_reg;
        out_live_next   = out_live_reg;
        hist_we         = 1'b0;
        bank_we         = '0;

        // Configuration writes.
        if (cfg_we)
        begin
            if (cfg_index == xfir_pkg::REG_XFADE_LEN)
            begin
                xlen_next = cfg_data[XW-1:0];
            end
            else if (cfg_index == xfir_pkg::REG_XFADE_RECIP)
            begin
                xrecip_next = cfg_data[xfir_pkg::XRECIP_W-1:0];
            end
        end

        // A taken result frees the output register.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        xfir_pkg::CMD_TAP:
                        begin
                            for (int b = 0; b < 3; b++)
                            begin
                                bank_we[b] = tap_ok && (pend_reg == bank_t'(b));
                            end
                        end
                        xfir_pkg::CMD_PUBLISH:
                        begin
                            if (item.ir_length != '0)
                            begin
                                len_next[pend_reg] = ir_len_clamped;
                                pending_next       = 1'b1;
                            end
                        end
                        xfir_pkg::CMD_CLEAR:
                        begin
                            ptr_next  = '0;
                            fill_next = '0;
                            if (rem_reg != '0)
                            begin
                                live_next = next_reg;
                                next_next = live_reg;
                                rem_next  = '0;
                            end
                        end
                        xfir_pkg::CMD_AUDIO:
                        begin
                            next_next    = a_nx2;
                            pend_next    = a_pend;
                            live_next    = a_live;
                            pending_next = pending_reg && !adopt;
                            loaded_next  = loaded_reg || adopt;
                            if (!(loaded_reg || adopt))
                            begin
                                // Passthrough until a response is adopted.
                                res_left_next   = item.left_in;
                                res_right_next  = item.right_in;
                                res_fading_next = 1'b0;
                                res_live_next   = 1'b0;
                                state_next      = ST_DELIVER;
                            end
                            else
                            begin
                                hist_we        = 1'b1;
                                cur_bank_next  = a_live;
                                nxt_bank_next  = a_nx2;
                                len_cur_next   = a_len_live;
                                len_nxt_next   = a_len_nxt;
                                klen_next      = (a_len_nxt > a_len_live) ? a_len_nxt
                                                                          : a_len_live;
                                fade_next      = fade_now;
                                rem_snap_next  = a_rem;
                                ptr_snap_next  = ptr_reg;
                                fill_snap_next = (fill_reg == LW'(MAX_TAPS)) ? fill_reg
                                                 : fill_reg + LW'(1);
                                fill_next      = fill_snap_next;
                                ptr_next       = (ptr_reg == AW'(MAX_TAPS - 1)) ? '0
                                                 : ptr_reg + AW'(1);
                                rem_next       = fade_now ? rem_dec : a_rem;
                                if (fade_end)
                                begin
                                    live_next = a_nx2;
                                    next_next = a_live;
                                end
                                k_next     = '0;
                                state_next = ST_RUN;
                            end
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                k_next = k_reg + LW'(1);
                if (k_reg == k_last)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_MIXGO;
                end
            end
            ST_MIXGO:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (mix_done)
                begin
                    res_left_next   = mix_y[0];
                    res_right_next  = mix_y[1];
                    res_fading_next = fade_reg;
                    res_live_next   = 1'b1;
                    state_next      = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_left_next   = res_left_reg;
                    out_right_next  = res_right_reg;
                    out_fading_next = res_fading_reg;
                    out_live_next   = res_live_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            xlen_reg      <= xfir_pkg::XLEN_RESET;
            xrecip_reg    <= xfir_pkg::XRECIP_RESET;
            live_reg      <= xfir_pkg::BANK_A;
            next_reg      <= xfir_pkg::BANK_B;
            pend_reg      <= xfir_pkg::BANK_C;
            len_reg       <= '{default: '0};
            pending_reg   <= 1'b0;
            loaded_reg    <= 1'b0;
            rem_reg       <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            drain_reg     <= 1'b0;
            en_cur_reg    <= 1'b0;
            en_nxt_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            xlen_reg      <= xlen_next;
            xrecip_reg    <= xrecip_next;
            live_reg      <= live_next;
            next_reg      <= next_next;
            pend_reg      <= pend_next;
            len_reg       <= len_next;
            pending_reg   <= pending_next;
            loaded_reg    <= loaded_next;
            rem_reg       <= rem_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            en_cur_reg    <= (state_reg == ST_RUN) && (k_reg < len_cur_reg)
                             && (k_reg < fill_snap_reg);
            en_nxt_reg    <= (state_reg == ST_RUN) && (k_reg < len_nxt_reg)
                             && (k_reg < fill_snap_reg);
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_bank_reg   <= cur_bank_next;
        nxt_bank_reg   <= nxt_bank_next;
        len_cur_reg    <= len_cur_next;
        len_nxt_reg    <= len_nxt_next;
        klen_reg       <= klen_next;
        fill_snap_reg  <= fill_snap_next;
        ptr_snap_reg   <= ptr_snap_next;
        fade_reg       <= fade_next;
        rem_snap_reg   <= rem_snap_next;
        prod_reg       <= PW'(rem_snap_reg) * PW'(xrecip_reg);
        res_left_reg   <= res_left_next;
        res_right_reg  <= res_right_next;
        res_fading_reg <= res_fading_next;
        res_live_reg   <= res_live_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_fading_reg <= out_fading_next;
        out_live_reg   <= out_live_next;
    end

    // Sample history, one RAM per channel.
    xfir_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_hist_l (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (item.left_in),
        .raddr (hist_raddr),
        .rdata (hist_l_q)
    );

    xfir_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_hist_r (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (item.right_in),
        .raddr (hist_raddr),
        .rdata (hist_r_q)
    );

    // Three tap banks, all read at the current tap position.
    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        xfir_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (AW'(item.tap_index)),
            .wdata (item.tap_value),
            .raddr (k_reg[AW-1:0]),
            .rdata (bank_q[b])
        );
    end

    // Bank selection for the live and next lanes.
    always_comb
    begin
        unique case (cur_bank_reg)
            xfir_pkg::BANK_A: tap_cur = bank_q[0];
            xfir_pkg::BANK_B: tap_cur = bank_q[1];
            xfir_pkg::BANK_C: tap_cur = bank_q[2];
            default:          tap_cur = '0;
        endcase
        unique case (nxt_bank_reg)
            xfir_pkg::BANK_A: tap_nxt = bank_q[0];
            xfir_pkg::BANK_B: tap_nxt = bank_q[1];
            xfir_pkg::BANK_C: tap_nxt = bank_q[2];
            default:          tap_nxt = '0;
        endcase
    end

    assign ctl_cur = '{clr: accept && (item.cmd == xfir_pkg::CMD_AUDIO), en: en_cur_reg};
    assign ctl_nxt = '{clr: accept && (item.cmd == xfir_pkg::CMD_AUDIO), en: en_nxt_reg};

    // Four MAC lanes: left and right for each of the two responses.
    xfir_lane #(.ACC_W(ACC_W)) u_lane_cl (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_cur),
        .tap (tap_cur), .smp (hist_l_q), .acc (acc_cur[0])
    );

    xfir_lane #(.ACC_W(ACC_W)) u_lane_cr (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_cur),
        .tap (tap_cur), .smp (hist_r_q), .acc (acc_cur[1])
    );

    xfir_lane #(.ACC_W(ACC_W)) u_lane_nl (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_nxt),
        .tap (tap_nxt), .smp (hist_l_q), .acc (acc_nxt[0])
    );

    xfir_lane #(.ACC_W(ACC_W)) u_lane_nr (
        .clk (clk), .rst_n (rst_n), .ctl (ctl_nxt),
        .tap (tap_nxt), .smp (hist_r_q), .acc (acc_nxt[1])
    );

    // Merge the lane sums into the output frame.
    assign mix_ctl = '{start: (state_reg == ST_MIXGO), fade: fade_reg, prod: prod_reg};

    xfir_mix #(.ACC_W(ACC_W)) u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mix_ctl),
        .acc_cur (acc_cur),
        .acc_nxt (acc_nxt),
        .done    (mix_done),
        .y_out   (mix_y)
    );

    // Result channel.
    assign result.valid     = out_valid_reg;
    assign result.left_out  = out_left_reg;
    assign result.right_out = out_right_reg;
    assign result.fading    = out_fading_reg;
    assign result.ir_live   = out_live_reg;

    // A fade can only run once a response is live.
    `ASSERT_IMPLY(a_fade_needs_ir, clk, rst_n, rem_reg != '0, loaded_reg)
    // The three bank roles always name different banks.
    `ASSERT_IMPLY(a_roles_distinct, clk, rst_n, 1'b1, (live_reg != next_reg) && (live_reg != pend_reg) && (next_reg != pend_reg))
    // The merging stage only finishes while the sequencer waits for it.
    `ASSERT_IMPLY(a_mix_in_wait, clk, rst_n, mix_done, state_reg == ST_MIX)
    // Delivery into a free output register shows a result next cycle.
    `ASSERT_NEXT(a_deliver_loads, clk, rst_n, (state_reg == ST_DELIVER) && !out_valid_reg, out_valid_reg)

endmodule
